>>> hw/rtl/fat_table_entry_access_macros.svh
// ---------------------------------------------------------------------------
// fat table entry access assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef FAT_TABLE_ENTRY_ACCESS_MACROS_SVH
`define FAT_TABLE_ENTRY_ACCESS_MACROS_SVH

// same-cycle implication, held off while reset is high
`define FTA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off while reset is high
`define FTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/fta_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fta_pkg
// types and constants of the allocation table entry access block
// ---------------------------------------------------------------------------
package fta_pkg;

   // operation codes
   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_FORMAT = 2'd2;

   // register indexes
   localparam logic REG_ENTRY_FORMAT = 1'b0;
   localparam logic REG_USED_BYTES   = 1'b1;

   // entry masks and media fill patterns
   localparam logic [15:0] MEDIA_HIGH_12 = 16'h0F00;
   localparam logic [15:0] MEDIA_HIGH_16 = 16'hFF00;
   localparam logic [15:0] MASK_ENTRY_12 = 16'h0FFF;
   localparam logic [15:0] MASK_LOW_NIB  = 16'h000F;
   localparam logic [15:0] MASK_HIGH_NIB = 16'hF000;

   typedef struct packed {
      logic [1:0]  operation;
      logic [12:0] entry_index;
      logic [15:0] entry_value;
      logic [7:0]  media_type;
   } req_beat_type;

   typedef struct packed {
      logic [15:0] entry_data;
      logic        range_error;
   } rsp_beat_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_FORMAT,
      ST_REPLY
   } state_type;

endpackage

>>> hw/rtl/fta_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fta_ram
// single-port synchronous ram with registered read data
// ---------------------------------------------------------------------------
module fta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/fat_table_entry_access.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fat_table_entry_access
// allocation table entry read, write and format in 12-bit or 16-bit layout
// ---------------------------------------------------------------------------
// usage:
//   req_* carries one request beat (read, write or format) with valid/stall;
//   rsp_* returns one result beat per request, entry_data plus range_error.
//   csr_* writes entry_format (index 0) and used_bytes (index 1); the user
//   must write only while idle, which the block itself does not enforce.
//   the table sits in two byte banks (even and odd bytes), so an entry pair
//   is read in the read state and rewritten in the modify state, which
//   also loads the result; a new beat is taken only back in idle, and
//   unused codes go straight to the reply state.
//   a format sweeps one row of two bytes a cycle over ceil(limit/2) rows
//   (at least one), limit being min(used_bytes, TABLE_BYTES); its result
//   is loaded in the reply state that follows, and entries 0 and 1 are
//   laid down by the same sweep.
// reset:
//   after reset the banks are zeroed, one row a cycle, over all
//   (TABLE_BYTES+1)/2 rows; req_stall stays high until this finishes.
// stall:
//   the result is held in an output register while rsp_stall is high; the
//   next beat may still be taken, but it waits before its write-back or reply
//   with req_stall high until the register frees.
// ---------------------------------------------------------------------------
module fat_table_entry_access #(
   parameter int TABLE_BYTES = 8192
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fta_pkg::req_beat_type req_beat,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fta_pkg::rsp_beat_type rsp_beat,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [13:0]          csr_wdata
);

   localparam int ROWS = (TABLE_BYTES + 1) / 2;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CWX  = $clog2(TABLE_BYTES + 1) + 1;
   localparam int CW   = (CWX > 15) ? CWX : 15;

   fta_pkg::state_type    state_ff, state_in;
   logic [RW-1:0]         sweep_ff, sweep_in;
   fta_pkg::req_beat_type req_ff, req_in;
   logic                  fmt_ff, fmt_in;
   logic [13:0]           used_ff, used_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fta_pkg::rsp_beat_type rsp_ff, rsp_in;

   logic          req_take;
   logic          out_free;
   logic          sweep_last;
   logic          clear_last;
   logic [CW-1:0] limit;
   logic [CW-1:0] used_ext;
   logic [CW-1:0] idx_ext;
   logic [CW-1:0] pair_off;
   logic          in_range;
   logic          fmt_error;
   logic [CW-1:0] byte_even;
   logic [CW-1:0] byte_odd;
   logic [15:0]   entry0_val;
   logic [15:0]   pair;
   logic [15:0]   entry_old;
   logic [15:0]   pair_new;
   logic [7:0]    lo_q;
   logic [7:0]    hi_q;

   logic          even_we, odd_we;
   logic [RW-1:0] even_addr, odd_addr;
   logic [7:0]    even_wdata, odd_wdata;
   logic [7:0]    even_rdata, odd_rdata;

   // byte banks: even table bytes in one, odd in the other
   fta_ram #(.WIDTH(8), .DEPTH(ROWS)) u_even_ram (
      .clock (clock),
      .we    (even_we),
      .addr  (even_addr),
      .wdata (even_wdata),
      .rdata (even_rdata)
   );

   fta_ram #(.WIDTH(8), .DEPTH(ROWS)) u_odd_ram (
      .clock (clock),
      .we    (odd_we),
      .addr  (odd_addr),
      .wdata (odd_wdata),
      .rdata (odd_rdata)
   );

   // handshake qualifiers
   assign req_take = req_valid && (state_ff == fta_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // bytes in use and entry placement
   assign used_ext = CW'(used_ff);
   assign limit    = (used_ext < CW'(TABLE_BYTES)) ? used_ext : CW'(TABLE_BYTES);
   assign idx_ext  = CW'(req_ff.entry_index);
   assign pair_off = fmt_ff ? (idx_ext << 1) : (idx_ext + (idx_ext >> 1));
   assign in_range = (pair_off + CW'(1)) < limit;

   // format sweep positions and the reserved entries
   assign byte_even  = CW'(sweep_ff) << 1;
   assign byte_odd   = byte_even + CW'(1);
   assign sweep_last = (byte_even + CW'(2)) >= limit;
   assign clear_last = (sweep_ff == RW'(ROWS - 1));
   assign entry0_val = (fmt_ff ? fta_pkg::MEDIA_HIGH_16 : fta_pkg::MEDIA_HIGH_12)
                       | {8'h00, req_ff.media_type};
   assign fmt_error  = (limit <= CW'(1)) || (fmt_ff ? (limit <= CW'(3)) : (limit <= CW'(2)));

   // entry pair as read, old entry and rewritten pair
   assign lo_q = pair_off[0] ? odd_rdata : even_rdata;
   assign hi_q = pair_off[0] ? even_rdata : odd_rdata;
   assign pair = {hi_q, lo_q};

   always_comb begin
      if (fmt_ff) begin
         entry_old = pair;
         pair_new  = req_ff.entry_value;
      end else if (req_ff.entry_index[0]) begin
         entry_old = pair >> 4;
         pair_new  = (pair & fta_pkg::MASK_LOW_NIB)
                     | ((req_ff.entry_value & fta_pkg::MASK_ENTRY_12) << 4);
      end else begin
         entry_old = pair & fta_pkg::MASK_ENTRY_12;
         pair_new  = (pair & fta_pkg::MASK_HIGH_NIB)
                     | (req_ff.entry_value & fta_pkg::MASK_ENTRY_12);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fta_pkg::ST_CLEAR: begin
            if (clear_last) state_in = fta_pkg::ST_IDLE;
         end
         fta_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_beat.operation)
                  fta_pkg::OP_READ:   state_in = fta_pkg::ST_READ;
                  fta_pkg::OP_WRITE:  state_in = fta_pkg::ST_READ;
                  fta_pkg::OP_FORMAT: state_in = fta_pkg::ST_FORMAT;
                  default:            state_in = fta_pkg::ST_REPLY;
               endcase
            end
         end
         fta_pkg::ST_READ: begin
            state_in = fta_pkg::ST_MODIFY;
         end
         fta_pkg::ST_MODIFY: begin
            if (out_free) state_in = fta_pkg::ST_IDLE;
         end
         fta_pkg::ST_FORMAT: begin
            if (sweep_last) state_in = fta_pkg::ST_REPLY;
         end
         fta_pkg::ST_REPLY: begin
            if (out_free) state_in = fta_pkg::ST_IDLE;
         end
         default: begin
            state_in = fta_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs: memory controls, result load, request capture
   always_comb begin
      req_stall    = (state_ff != fta_pkg::ST_IDLE);
      even_we      = 1'b0;
      odd_we       = 1'b0;
      even_addr    = pair_off[0] ? RW'((pair_off >> 1) + CW'(1)) : RW'(pair_off >> 1);
      odd_addr     = RW'(pair_off >> 1);
      even_wdata   = pair_off[0] ? pair_new[15:8] : pair_new[7:0];
      odd_wdata    = pair_off[0] ? pair_new[7:0] : pair_new[15:8];
      sweep_in     = '0;
      req_in       = req_take ? req_beat : req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         fta_pkg::ST_CLEAR: begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_addr  = sweep_ff;
            odd_addr   = sweep_ff;
            even_wdata = '0;
            odd_wdata  = '0;
            sweep_in   = sweep_ff + RW'(1);
         end
         fta_pkg::ST_MODIFY: begin
            if (out_free) begin
               even_we            = (req_ff.operation == fta_pkg::OP_WRITE) && in_range;
               odd_we             = even_we;
               rsp_in.entry_data  = in_range ? entry_old : 16'h0000;
               rsp_in.range_error = !in_range;
               rsp_valid_in       = 1'b1;
            end
         end
         fta_pkg::ST_FORMAT: begin
            even_we    = byte_even < limit;
            odd_we     = byte_odd < limit;
            even_addr  = sweep_ff;
            odd_addr   = sweep_ff;
            even_wdata = '0;
            odd_wdata  = '0;
            // entry 0 in the first row, the end marker spills into the second
            if (sweep_ff == RW'(0)) begin
               even_wdata = (limit > CW'(1)) ? entry0_val[7:0] : 8'h00;
               odd_wdata  = fmt_ff ? entry0_val[15:8]
                          : ((limit > CW'(2)) ? {req_ff.entry_value[3:0], entry0_val[11:8]}
                                              : entry0_val[15:8]);
            end else if (sweep_ff == RW'(1)) begin
               if (fmt_ff) begin
                  even_wdata = (limit > CW'(3)) ? req_ff.entry_value[7:0] : 8'h00;
                  odd_wdata  = (limit > CW'(3)) ? req_ff.entry_value[15:8] : 8'h00;
               end else begin
                  even_wdata = (limit > CW'(2)) ? req_ff.entry_value[11:4] : 8'h00;
               end
            end
            sweep_in = sweep_ff + RW'(1);
         end
         fta_pkg::ST_REPLY: begin
            if (out_free) begin
               rsp_in.entry_data  = 16'h0000;
               rsp_in.range_error = (req_ff.operation == fta_pkg::OP_FORMAT) && fmt_error;
               rsp_valid_in       = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // configuration writes
   always_comb begin
      fmt_in  = fmt_ff;
      used_in = used_ff;
      if (csr_we) begin
         case (csr_index)
            fta_pkg::REG_ENTRY_FORMAT: fmt_in  = csr_wdata[0];
            fta_pkg::REG_USED_BYTES:   used_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fta_pkg::ST_CLEAR;
         sweep_ff     <= '0;
         fmt_ff       <= 1'b0;
         used_ff      <= 14'd8192;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         fmt_ff       <= fmt_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

>>> hw/rtl/fta_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fta_checker
// port-level checks of the allocation table entry access block
// ---------------------------------------------------------------------------
`include "fat_table_entry_access_macros.svh"

module fta_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input fta_pkg::req_beat_type req_beat,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input fta_pkg::rsp_beat_type rsp_beat
);

   // a stalled result beat holds
   `FTA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat), "result beat changed under stall")

   // table clearing keeps the request side stalled straight after reset
   `FTA_ASSERT_SAME(a_clear_stall, clock, reset, $past(reset), req_stall, "request taken during clearing")

   // one item at a time: an accepted beat stalls the next
   `FTA_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall, "second beat taken while busy")

   // a range error never carries entry data
   `FTA_ASSERT_SAME(a_err_data, clock, reset, rsp_valid && rsp_beat.range_error, rsp_beat.entry_data == 16'h0000, "range error with entry data")

endmodule

bind fat_table_entry_access fta_checker u_fta_checker (.*);

>>> tb/fat_table_entry_access_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fat_table_entry_access_test
// self-checking bench for the allocation table entry access block: a
// directed table covers the edges of both layouts, tiny and clamped
// tables and the unused code, then randomised phases of reads, writes,
// formats and unused codes run against a byte-level table predictor
// ---------------------------------------------------------------------------
module fat_table_entry_access_test;

   localparam int TABLE_BYTES    = 8192;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASES         = 9;
   localparam int PHASE_ITEMS    = 45;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      bit                     is_reg;
      logic                   reg_idx;
      logic [13:0]            reg_val;
      fta_pkg::req_beat_type  beat;
      bit                     typed;
      fta_pkg::rsp_beat_type  want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   fta_pkg::req_beat_type req_beat = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   fta_pkg::rsp_beat_type rsp_beat;
   logic                  csr_we = 1'b0;
   logic                  csr_index = fta_pkg::REG_ENTRY_FORMAT;
   logic [13:0]           csr_wdata = '0;

   // table predictor state
   logic [7:0]    fat_bytes [0:TABLE_BYTES-1];
   logic          fmt_sel;
   logic [13:0]   used_cnt;

   fta_pkg::rsp_beat_type pending_rsp [$];
   plan_row_type          directed [$];
   fta_pkg::rsp_beat_type oldest;
   int            fail_count = 0;
   int            idle_cycles = 0;
   int            stall_left = 0;
   int            idle_pct = 0;
   int            stall_pct = 0;
   int            top_idx;

   bit          phase_fmt  [PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 1};
   int          phase_used [PHASES] = '{8192, 8192, 4, 5, 600, 12000, 1, 3, 8192};
   int          phase_gap  [PHASES] = '{25, 0, 40, 10, 60, 20, 30, 15, 0};
   int          phase_hold [PHASES] = '{5, 10, 0, 20, 8, 3, 12, 6, 0};

   fat_table_entry_access #(.TABLE_BYTES(TABLE_BYTES)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bytes in use, clamped to the table size
   function automatic int table_limit();
      return (used_cnt < TABLE_BYTES) ? int'(used_cnt) : TABLE_BYTES;
   endfunction

   // offset of the byte pair holding an entry
   function automatic int pair_at(int idx);
      return fmt_sel ? idx * 2 : idx + (idx >> 1);
   endfunction

   function automatic bit entry_fits(int idx);
      return pair_at(idx) + 1 < table_limit();
   endfunction

   function automatic logic [15:0] entry_get(int idx);
      logic [15:0] pair;
      pair = {fat_bytes[pair_at(idx) + 1], fat_bytes[pair_at(idx)]};
      if (fmt_sel)
         return pair;
      return idx[0] ? (pair >> 4) : (pair & fta_pkg::MASK_ENTRY_12);
   endfunction

   // packed entries keep the neighbour's nibble in the shared byte
   function automatic void entry_put(int idx, logic [15:0] value);
      int          off;
      logic [15:0] pair;
      off  = pair_at(idx);
      pair = {fat_bytes[off + 1], fat_bytes[off]};
      if (fmt_sel)
         pair = value;
      else if (idx[0])
         pair = (pair & fta_pkg::MASK_LOW_NIB) | ((value & fta_pkg::MASK_ENTRY_12) << 4);
      else
         pair = (pair & fta_pkg::MASK_HIGH_NIB) | (value & fta_pkg::MASK_ENTRY_12);
      fat_bytes[off]     = pair[7:0];
      fat_bytes[off + 1] = pair[15:8];
   endfunction

   // expected result of one request beat, updating the predicted table
   function automatic fta_pkg::rsp_beat_type table_access(fta_pkg::req_beat_type b);
      fta_pkg::rsp_beat_type r;
      int                    idx;
      r   = '0;
      idx = int'(b.entry_index);
      case (b.operation)
         fta_pkg::OP_READ, fta_pkg::OP_WRITE: begin
            if (!entry_fits(idx)) begin
               r.range_error = 1'b1;
            end else begin
               r.entry_data = entry_get(idx);
               if (b.operation == fta_pkg::OP_WRITE)
                  entry_put(idx, b.entry_value);
            end
         end
         fta_pkg::OP_FORMAT: begin
            for (int i = 0; i < table_limit(); i++)
               fat_bytes[i] = 8'h00;
            if (entry_fits(0))
               entry_put(0, (fmt_sel ? fta_pkg::MEDIA_HIGH_16 : fta_pkg::MEDIA_HIGH_12)
                            | {8'h00, b.media_type});
            else
               r.range_error = 1'b1;
            if (entry_fits(1))
               entry_put(1, b.entry_value);
            else
               r.range_error = 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic plan_row_type item_row(logic [1:0] op, int idx, int value, int media);
      plan_row_type r;
      r.is_reg  = 1'b0;
      r.reg_idx = fta_pkg::REG_ENTRY_FORMAT;
      r.reg_val = '0;
      r.beat    = '{operation: op, entry_index: 13'(idx), entry_value: 16'(value),
                    media_type: 8'(media)};
      r.typed   = 1'b0;
      r.want    = '0;
      return r;
   endfunction

   function automatic plan_row_type known_row(logic [1:0] op, int idx, int value, int media,
                                              logic [15:0] data, logic err);
      plan_row_type r;
      r       = item_row(op, idx, value, media);
      r.typed = 1'b1;
      r.want  = '{entry_data: data, range_error: err};
      return r;
   endfunction

   function automatic plan_row_type reg_row(logic idx, int value);
      plan_row_type r;
      r         = item_row(fta_pkg::OP_READ, 0, 0, 0);
      r.is_reg  = 1'b1;
      r.reg_idx = idx;
      r.reg_val = 14'(value);
      return r;
   endfunction

   // random request: mostly in-range accesses, clustered low and at the top edge
   function automatic fta_pkg::req_beat_type random_req();
      fta_pkg::req_beat_type b;
      int                    pick;
      int                    idx;
      b.entry_value = 16'($urandom_range(0, 65535));
      b.media_type  = 8'($urandom_range(0, 255));
      b.entry_index = 13'($urandom_range(0, 8191));
      pick = $urandom_range(0, 99);
      if (pick < 4)
         b.operation = fta_pkg::OP_FORMAT;
      else if (pick < 7)
         b.operation = OP_UNUSED;
      else
         b.operation = (pick < 52) ? fta_pkg::OP_READ : fta_pkg::OP_WRITE;
      if (top_idx >= 0 && pick >= 7 && $urandom_range(0, 9) != 0) begin
         case ($urandom_range(0, 2))
            0: idx = $urandom_range(0, top_idx);
            1: idx = top_idx + 2 - int'($urandom_range(0, 9));
            default: idx = $urandom_range(0, (top_idx < 15) ? top_idx : 15);
         endcase
         b.entry_index = 13'((idx < 0) ? 0 : idx);
      end
      return b;
   endfunction

   // one request beat; the expectation is queued when the beat is taken
   task automatic send_item(fta_pkg::req_beat_type b, bit typed,
                            fta_pkg::rsp_beat_type want);
      fta_pkg::rsp_beat_type r;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= b;
      do
         @(posedge clock);
      while (req_stall);
      r = table_access(b);
      pending_rsp.push_back(typed ? want : r);
   endtask

   // register write once the block has drained
   task automatic write_reg(logic idx, logic [13:0] value);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == fta_pkg::REG_ENTRY_FORMAT)
         fmt_sel = value[0];
      else
         used_cnt = value;
   endtask

   // result-side stall bursts
   always @(posedge clock) begin
      if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(1, 18);
         rsp_stall  <= 1'b1;
      end
   end

   // result beat check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result beat with no request outstanding");
            fail_count++;
         end else begin
            oldest = pending_rsp.pop_front();
            if (rsp_beat.entry_data !== oldest.entry_data) begin
               $error("entry_data: expected %h, got %h", oldest.entry_data,
                      rsp_beat.entry_data);
               fail_count++;
            end
            if (rsp_beat.range_error !== oldest.range_error) begin
               $error("range_error: expected %b, got %b", oldest.range_error,
                      rsp_beat.range_error);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < TABLE_BYTES; i++)
         fat_bytes[i] = 8'h00;
      fmt_sel  = 1'b0;
      used_cnt = 14'd8192;

      // 12-bit layout, full table: edges, writes, unused code, format
      directed.push_back(known_row(fta_pkg::OP_READ, 0, 0, 0, 16'h0000, 1'b0));
      directed.push_back(known_row(fta_pkg::OP_READ, 5460, 0, 0, 16'h0000, 1'b0));
      directed.push_back(known_row(fta_pkg::OP_READ, 5461, 0, 0, 16'h0000, 1'b1));
      directed.push_back(known_row(fta_pkg::OP_WRITE, 5460, 16'hFFFF, 0, 16'h0000, 1'b0));
      directed.push_back(item_row(fta_pkg::OP_WRITE, 5459, 16'h1234, 0));
      directed.push_back(item_row(fta_pkg::OP_READ, 5459, 0, 0));
      directed.push_back(item_row(fta_pkg::OP_READ, 5460, 0, 0));
      directed.push_back(known_row(fta_pkg::OP_WRITE, 8191, 16'hFFFF, 8'hFF, 16'h0000, 1'b1));
      directed.push_back(known_row(OP_UNUSED, 8191, 16'hFFFF, 8'hFF, 16'h0000, 1'b0));
      directed.push_back(known_row(fta_pkg::OP_FORMAT, 0, 16'hFFFF, 8'hFF, 16'h0000, 1'b0));
      directed.push_back(item_row(fta_pkg::OP_READ, 0, 0, 0));
      directed.push_back(item_row(fta_pkg::OP_READ, 1, 0, 0));
      directed.push_back(item_row(fta_pkg::OP_READ, 5460, 0, 0));
      // 16-bit layout, used size above the table clamps
      directed.push_back(reg_row(fta_pkg::REG_ENTRY_FORMAT, 1));
      directed.push_back(reg_row(fta_pkg::REG_USED_BYTES, 16383));
      directed.push_back(item_row(fta_pkg::OP_READ, 4095, 0, 0));
      directed.push_back(known_row(fta_pkg::OP_READ, 4096, 0, 0, 16'h0000, 1'b1));
      directed.push_back(item_row(fta_pkg::OP_WRITE, 0, 16'hABCD, 0));
      directed.push_back(item_row(fta_pkg::OP_READ, 0, 0, 0));
      // smallest legal 16-bit table, tables too small for the reserved entries, smallest 12-bit one
      directed.push_back(reg_row(fta_pkg::REG_USED_BYTES, 4));
      directed.push_back(known_row(fta_pkg::OP_FORMAT, 0, 16'h0000, 8'h00, 16'h0000, 1'b0));
      directed.push_back(item_row(fta_pkg::OP_READ, 1, 0, 0));
      directed.push_back(known_row(fta_pkg::OP_READ, 2, 0, 0, 16'h0000, 1'b1));
      directed.push_back(reg_row(fta_pkg::REG_USED_BYTES, 2));
      directed.push_back(known_row(fta_pkg::OP_FORMAT, 0, 16'hFFF7, 8'hF8, 16'h0000, 1'b1));
      directed.push_back(item_row(fta_pkg::OP_READ, 0, 0, 0));
      directed.push_back(reg_row(fta_pkg::REG_ENTRY_FORMAT, 0));
      directed.push_back(reg_row(fta_pkg::REG_USED_BYTES, 0));
      directed.push_back(known_row(fta_pkg::OP_FORMAT, 0, 16'hFFF7, 8'hF0, 16'h0000, 1'b1));
      directed.push_back(known_row(fta_pkg::OP_READ, 0, 0, 0, 16'h0000, 1'b1));
      directed.push_back(reg_row(fta_pkg::REG_USED_BYTES, 3));
      directed.push_back(known_row(fta_pkg::OP_FORMAT, 0, 16'hFFF8, 8'hF9, 16'h0000, 1'b0));
      directed.push_back(item_row(fta_pkg::OP_READ, 1, 0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      idle_pct  = 20;
      stall_pct = 5;
      foreach (directed[i]) begin
         if (directed[i].is_reg)
            write_reg(directed[i].reg_idx, directed[i].reg_val);
         else
            send_item(directed[i].beat, directed[i].typed, directed[i].want);
      end

      // random phases, each opening with a format; the last one runs flat out
      for (int p = 0; p < PHASES; p++) begin
         write_reg(fta_pkg::REG_ENTRY_FORMAT, 14'(phase_fmt[p]));
         write_reg(fta_pkg::REG_USED_BYTES, 14'(phase_used[p]));
         idle_pct  = phase_gap[p];
         stall_pct = phase_hold[p];
         top_idx = fmt_sel ? table_limit() / 2 : (2 * table_limit()) / 3 + 1;
         while (top_idx >= 0 && !entry_fits(top_idx))
            top_idx--;
         send_item(item_row(fta_pkg::OP_FORMAT, 0, $urandom_range(0, 65535),
                            $urandom_range(0, 255)).beat, 1'b0, '0);
         for (int n = 1; n < PHASE_ITEMS; n++)
            send_item(random_req(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/fta_pkg.sv
hw/rtl/fta_ram.sv
hw/rtl/fat_table_entry_access.sv
hw/rtl/fta_checker.sv
tb/fat_table_entry_access_test.sv
